@@ hdl/ugmc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the unit-capacity min cut block.
// No dependencies; every other file imports this package.
package ugmc_pkg;

  localparam int NODE_W        = 5;
  localparam int FLOW_W        = 6;
  localparam int DEF_MAX_NODES = 16;
  localparam int DEF_MAX_EDGES = 32;

  localparam logic [NODE_W-1:0] NODE_COUNT_RESET = NODE_W'(16);

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_SOLVE  = 1'b1;
  localparam logic KIND_FLOW = 1'b0;
  localparam logic KIND_CUT  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic add_edge;
    logic bfs_init;
    logic bfs_pop;
    logic bfs_step;
    logic aug_init;
    logic aug_step;
    logic emit_init;
    logic emit_step;
    logic finish;
  } ugmc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic queue_empty;
    logic found;
    logic scan_last;
    logic at_source;
    logic emit_end;
    logic can_push;
  } ugmc_status_t;

endpackage

@@ hdl/ugmc_if.sv @@
`timescale 1ns / 1ps
// Channel interfaces: edge/solve input, result output, node count write.
// Depends on ugmc_pkg.
interface ugmc_in_if import ugmc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;
  modport source (output valid, operation, node_a, node_b, input ready);
  modport sink   (input valid, operation, node_a, node_b, output ready);
endinterface

interface ugmc_out_if import ugmc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [FLOW_W-1:0] flow_value;
  logic [NODE_W-1:0] cut_from;
  logic [NODE_W-1:0] cut_to;
  logic              last;
  modport source (output valid, kind, flow_value, cut_from, cut_to, last, input ready);
  modport sink   (input valid, kind, flow_value, cut_from, cut_to, last, output ready);
endinterface

interface ugmc_cfg_if import ugmc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] node_count;
  modport source (output valid, node_count, input ready);
  modport sink   (input valid, node_count, output ready);
endinterface

@@ hdl/unit_graph_min_cut_top.sv @@
`timescale 1ns / 1ps
// Top level of the unit-capacity min cut block: controller plus datapath.
// Depends on ugmc_pkg, ugmc_if, ugmc_ctrl and ugmc_datapath.
//
//  Channel  Direction  Carries
//  in_ch    sink       operation, node_a, node_b (add edge or solve)
//  out_ch   source     kind, flow_value, cut_from, cut_to, last
//  cfg      sink       node_count write, always ready
//
// Edge loads are accepted back to back while the block is idle.
// A solve repeats a breadth-first search, one stored edge examined per cycle
// through the single edge-list read port, and walks each augmenting path back
// to the source. Result emission scans each reached node against every edge,
// one pair per cycle, stalling while the output register is full. Synchronous
// reset clears the edge list, flows and output valid and sets node_count to
// 16. No input is taken during a solve.
module unit_graph_min_cut_top import ugmc_pkg::*; #(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int MAX_EDGES = DEF_MAX_EDGES
) (
  input logic        clk,
  input logic        rst,
  ugmc_in_if.sink    in_ch,
  ugmc_out_if.source out_ch,
  ugmc_cfg_if.sink   cfg
);

  ugmc_cmd_t    cmd;
  ugmc_status_t status;

  // configuration writes are taken at any time; the block is idle by contract
  assign cfg.ready = 1'b1;

  ugmc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.operation),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  ugmc_datapath #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .in_node_a      (in_ch.node_a),
    .in_node_b      (in_ch.node_b),
    .cfg_fire       (cfg.valid && cfg.ready),
    .cfg_data       (cfg.node_count),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_kind       (out_ch.kind),
    .out_flow_value (out_ch.flow_value),
    .out_cut_from   (out_ch.cut_from),
    .out_cut_to     (out_ch.cut_to),
    .out_last       (out_ch.last)
  );

endmodule

@@ hdl/ugmc_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer for load, augmenting-path search, path walk and result emission.
// Depends on ugmc_pkg.
module ugmc_ctrl import ugmc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         in_op,
  output logic         in_ready,
  input  ugmc_status_t status,
  output ugmc_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_BFS_INIT, S_BFS_POP, S_BFS_SCAN, S_AUG_INIT, S_AUG,
    S_EMIT_INIT, S_EMIT, S_LAST
  } state_t;

  state_t state, state_next;
  logic   in_fire;

  assign in_fire = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.add_edge = in_fire && (in_op == OP_ADD);
        if (in_fire && (in_op == OP_SOLVE)) state_next = S_BFS_INIT;
      end
      S_BFS_INIT: begin
        cmd.bfs_init = 1'b1;
        state_next   = S_BFS_POP;
      end
      S_BFS_POP: begin
        if (status.queue_empty) begin
          state_next = S_EMIT_INIT;
        end else begin
          cmd.bfs_pop = 1'b1;
          state_next  = S_BFS_SCAN;
        end
      end
      S_BFS_SCAN: begin
        cmd.bfs_step = 1'b1;
        if (status.found) state_next = S_AUG_INIT;
        else if (status.scan_last) state_next = S_BFS_POP;
      end
      S_AUG_INIT: begin
        cmd.aug_init = 1'b1;
        state_next   = S_AUG;
      end
      S_AUG: begin
        if (status.at_source) state_next = S_BFS_INIT;
        else cmd.aug_step = 1'b1;
      end
      S_EMIT_INIT: begin
        cmd.emit_init = 1'b1;
        state_next    = S_EMIT;
      end
      S_EMIT: begin
        if (status.emit_end) state_next = S_LAST;
        else cmd.emit_step = status.can_push;
      end
      S_LAST: begin
        if (status.can_push) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b1;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == S_IDLE);
    end
  end

endmodule

@@ hdl/ugmc_datapath.sv @@
`timescale 1ns / 1ps
// Edge list, per-edge flow, search queue, visited set and result registers.
// Depends on ugmc_pkg; driven by ugmc_ctrl.
module ugmc_datapath import ugmc_pkg::*; #(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int MAX_EDGES = DEF_MAX_EDGES
) (
  input  logic              clk,
  input  logic              rst,
  input  ugmc_cmd_t         cmd,
  output ugmc_status_t      status,
  input  logic [NODE_W-1:0] in_node_a,
  input  logic [NODE_W-1:0] in_node_b,
  input  logic              cfg_fire,
  input  logic [NODE_W-1:0] cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kind,
  output logic [FLOW_W-1:0] out_flow_value,
  output logic [NODE_W-1:0] out_cut_from,
  output logic [NODE_W-1:0] out_cut_to,
  output logic              out_last
);

  localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int Q_W   = $clog2(MAX_NODES + 1);
  localparam int EI_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EC_W  = $clog2(MAX_EDGES + 1);

  function automatic logic [IDX_W-1:0] ix(input logic [NODE_W-1:0] v);
    return IDX_W'(v - NODE_W'(1));
  endfunction

  logic [NODE_W-1:0]    node_count;
  logic [NODE_W-1:0]    n_act;
  logic [NODE_W-1:0]    edge_a [MAX_EDGES];
  logic [NODE_W-1:0]    edge_b [MAX_EDGES];
  logic [EC_W-1:0]      edge_total;
  logic [MAX_EDGES-1:0] fpos;
  logic [MAX_EDGES-1:0] fneg;
  logic [MAX_NODES-1:0] visited;
  logic [NODE_W-1:0]    queue [MAX_NODES];
  logic [EI_W-1:0]      parent_edge [MAX_NODES];
  logic [Q_W-1:0]       head, tail;
  logic [NODE_W-1:0]    cur;
  logic [EI_W-1:0]      scan_k;
  logic [FLOW_W-1:0]    flow;
  logic                 emit_done;
  logic                 pend_kind;
  logic [FLOW_W-1:0]    pend_flow;
  logic [NODE_W-1:0]    pend_from, pend_to;

  logic [EI_W-1:0]   rd_k;
  logic [NODE_W-1:0] ea, eb, nb, prev;
  logic              usable, k_ok, side0, touch, vis_nb, res_ok, relax, cut;
  logic              cur_reached, scan_last, can_push, push, add_ok;

  always_comb begin
    if (node_count < NODE_W'(2)) n_act = NODE_W'(2);
    else if (32'(node_count) > MAX_NODES) n_act = NODE_W'(MAX_NODES);
    else n_act = node_count;
  end

  // one edge read a cycle: the parent edge while walking a path, else the scan index
  assign rd_k   = cmd.aug_step ? parent_edge[ix(cur)] : scan_k;
  assign ea     = edge_a[rd_k];
  assign eb     = edge_b[rd_k];
  assign k_ok   = 32'(scan_k) < 32'(edge_total);
  assign usable = (ea != '0) && (ea <= n_act) && (eb != '0) && (eb <= n_act);
  assign side0  = (ea == cur);
  assign nb     = side0 ? eb : ea;
  assign touch  = k_ok && usable && ((ea == cur) || (eb == cur));
  assign vis_nb = visited[ix(nb)];
  assign res_ok = side0 ? !fpos[rd_k] : !fneg[rd_k];
  assign relax  = touch && !vis_nb && res_ok;
  assign cur_reached = visited[ix(cur)];
  assign cut       = touch && !vis_nb && cur_reached;
  assign scan_last = (32'(scan_k) + 32'd1) >= 32'(edge_total);
  assign prev      = (eb == cur) ? ea : eb;
  assign can_push  = !out_valid || out_ready;
  assign push      = (cmd.emit_step && cut) || cmd.finish;
  assign add_ok    = (32'(edge_total) < MAX_EDGES) && (in_node_a != '0) &&
                     (in_node_a <= n_act) && (in_node_b != '0) && (in_node_b <= n_act);

  assign status.queue_empty = (head == tail);
  assign status.found       = relax && (nb == n_act);
  assign status.scan_last   = scan_last;
  assign status.at_source   = (cur == NODE_W'(1));
  assign status.emit_end    = emit_done;
  assign status.can_push    = can_push;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
      edge_total <= '0;
      fpos       <= '0;
      fneg       <= '0;
      visited    <= '0;
      flow       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_fire) node_count <= cfg_data;
      if (cmd.add_edge && add_ok) edge_total <= edge_total + EC_W'(1);
      if (cmd.bfs_init) visited <= MAX_NODES'(1);
      if (cmd.bfs_step && relax) visited[ix(nb)] <= 1'b1;
      if (cmd.aug_init) flow <= flow + FLOW_W'(1);
      if (cmd.aug_step) begin
        if (eb == cur) begin
          if (fneg[rd_k]) fneg[rd_k] <= 1'b0;
          else fpos[rd_k] <= 1'b1;
        end else begin
          if (fpos[rd_k]) fpos[rd_k] <= 1'b0;
          else fneg[rd_k] <= 1'b1;
        end
      end
      if (cmd.finish) begin
        edge_total <= '0;
        fpos       <= '0;
        fneg       <= '0;
        visited    <= '0;
        flow       <= '0;
      end
      if (push) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // walk counters and payload
  always_ff @(posedge clk) begin
    if (cmd.add_edge && add_ok) begin
      edge_a[edge_total[EI_W-1:0]] <= in_node_a;
      edge_b[edge_total[EI_W-1:0]] <= in_node_b;
    end
    if (cmd.bfs_init) begin
      queue[0] <= NODE_W'(1);
      head     <= '0;
      tail     <= Q_W'(1);
    end
    if (cmd.bfs_pop) begin
      cur    <= queue[head[IDX_W-1:0]];
      head   <= head + Q_W'(1);
      scan_k <= '0;
    end
    if (cmd.bfs_step) begin
      scan_k <= scan_k + EI_W'(1);
      if (relax) begin
        parent_edge[ix(nb)] <= rd_k;
        if (32'(tail) < MAX_NODES) begin
          queue[tail[IDX_W-1:0]] <= nb;
          tail <= tail + Q_W'(1);
        end
      end
    end
    if (cmd.aug_init) cur <= n_act;
    if (cmd.aug_step) cur <= prev;
    if (cmd.emit_init) begin
      cur       <= NODE_W'(1);
      scan_k    <= '0;
      emit_done <= 1'b0;
      pend_kind <= KIND_FLOW;
      pend_flow <= flow;
      pend_from <= '0;
      pend_to   <= '0;
    end
    if (cmd.emit_step) begin
      if (!cur_reached || scan_last) begin
        scan_k <= '0;
        if (cur == n_act) emit_done <= 1'b1;
        else cur <= cur + NODE_W'(1);
      end else begin
        scan_k <= scan_k + EI_W'(1);
      end
      if (cut) begin
        pend_kind <= KIND_CUT;
        pend_flow <= '0;
        pend_from <= cur;
        pend_to   <= nb;
      end
    end
    if (push) begin
      out_kind       <= pend_kind;
      out_flow_value <= pend_flow;
      out_cut_from   <= pend_from;
      out_cut_to     <= pend_to;
      out_last       <= cmd.finish;
    end
  end

endmodule
